@@ hdl/vfc_pkg.sv @@
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared widths, codes and the face corner table of the voxel face-cull
// mesher.
// ----------------------------------------------------------------------------
package vfc_pkg;

    // Field widths
    localparam int COORD_W      = 8;
    localparam int TYPE_W       = 8;
    localparam int ORIGIN_W     = 12;
    localparam int VERT_W       = 17;
    localparam int FACE_W       = 3;
    localparam int VTX_W        = 3;
    localparam int CFG_IDX_W    = 2;

    // Geometry
    localparam int NUM_FACES    = 6;
    localparam int VTX_PER_FACE = 6;

    // Default cube edge length in cells
    localparam int EDGE_CELLS_DEF = 16;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_MESH  = 1'b1;

    // Face directions, in emission order
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;  // y + 1
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;  // y - 1
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;  // x - 1
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;  // x + 1
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd4;  // z - 1
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;  // z + 1

    // Index of the final vertex of a face
    localparam logic [VTX_W-1:0] LAST_VTX = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

    // Corner offsets of the two triangles of each face, packed {x, y, z}.
    localparam logic [2:0] CORNER_TAB [NUM_FACES][VTX_PER_FACE] = '{
        '{3'b010, 3'b011, 3'b110, 3'b110, 3'b011, 3'b111},
        '{3'b000, 3'b100, 3'b001, 3'b100, 3'b101, 3'b001},
        '{3'b011, 3'b001, 3'b010, 3'b010, 3'b001, 3'b000},
        '{3'b110, 3'b100, 3'b111, 3'b111, 3'b100, 3'b101},
        '{3'b010, 3'b000, 3'b110, 3'b110, 3'b000, 3'b100},
        '{3'b111, 3'b101, 3'b011, 3'b011, 3'b101, 3'b001}
    };

    // Corner offset of one vertex; codes outside the table give zero.
    function automatic logic [2:0] face_corner(input logic [FACE_W-1:0] face,
                                               input logic [VTX_W-1:0]  vtx);
        logic [2:0] corner;
        corner = 3'b000;
        if ((face < FACE_W'(NUM_FACES)) && (vtx < VTX_W'(VTX_PER_FACE)))
        begin
            corner = CORNER_TAB[face][vtx];
        end
        return corner;
    endfunction

endpackage

@@ hdl/vfc_if.sv @@
// ----------------------------------------------------------------------------
// vfc_if
// Valid/ready channels of the voxel face-cull mesher: input items,
// vertex results and configuration writes.
// ----------------------------------------------------------------------------

// Input item channel
interface vfc_item_if
    import vfc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [COORD_W-1:0]  cell_x;
    logic signed [COORD_W-1:0]  cell_y;
    logic signed [COORD_W-1:0]  cell_z;
    logic [TYPE_W-1:0]          new_type;

    modport source (
        output valid, kind, cell_x, cell_y, cell_z, new_type,
        input  ready
    );

    modport sink (
        input  valid, kind, cell_x, cell_y, cell_z, new_type,
        output ready
    );
endinterface

// Vertex result channel
interface vfc_vertex_if
    import vfc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [VERT_W-1:0]   vertex_x;
    logic signed [VERT_W-1:0]   vertex_y;
    logic signed [VERT_W-1:0]   vertex_z;
    logic [FACE_W-1:0]          face_dir;
    logic [TYPE_W-1:0]          cell_type;
    logic                       last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, vertex_z, face_dir, cell_type,
               last_vertex,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, vertex_z, face_dir, cell_type,
               last_vertex,
        output ready
    );
endinterface

// Configuration write channel
interface vfc_cfg_if
    import vfc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [CFG_IDX_W-1:0]       index;
    logic [ORIGIN_W-1:0]        data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hdl/voxel_face_cull_mesher_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher_unit
// Cube of block types with culled-face meshing. A write item stores a type;
// a mesh item emits six vertices for each exposed face of a solid cell.
// ----------------------------------------------------------------------------
//
//  Channel      Direction  Moves
//  -----------  ---------  ------------------------------------------------
//  cfg          in         register index and 12-bit chunk origin value
//  item_in      in         kind, cell_x/y/z, new_type
//  vertex_out   out        vertex_x/y/z, face_dir, cell_type, last_vertex
//
//  An item outside the cube is dropped and a mesh of an empty cell emits
//  nothing; a stalled vertex waits in the output register, and the next item
//  is taken while the final vertex still waits. After reset the store is
//  cleared one cell per cycle, all EDGE_CELLS^3 cells (4096 at the default
//  size); items wait, configuration writes are taken.
// ----------------------------------------------------------------------------
module voxel_face_cull_mesher_unit
    import vfc_pkg::*;
#(
    parameter int EDGE_CELLS = EDGE_CELLS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    vfc_cfg_if.sink      cfg,
    vfc_item_if.sink     item_in,
    vfc_vertex_if.source vertex_out
);

    localparam int CELL_COUNT = EDGE_CELLS * EDGE_CELLS * EDGE_CELLS;
    localparam int IDX_W      = $clog2(CELL_COUNT);
    localparam int EDGE_W     = $clog2(EDGE_CELLS + 1);
    localparam int ORG_W      = ORIGIN_W + EDGE_W + 1;
    localparam int SPAN_W     = IDX_W + 2;
    localparam int UNIT_W_A   = (ORG_W > SPAN_W) ? ORG_W : SPAN_W;
    localparam int UNIT_W     = (UNIT_W_A > VERT_W) ? UNIT_W_A : VERT_W;

    localparam logic [COORD_W-1:0] EDGE_U   = COORD_W'(EDGE_CELLS);
    localparam logic [COORD_W-1:0] EDGE_MAX = COORD_W'(EDGE_CELLS - 1);
    localparam logic [IDX_W-1:0]   CLR_LAST = IDX_W'(CELL_COUNT - 1);

    // Operands of the shared unit for neighbour steps
    localparam logic signed [UNIT_W-1:0] STEP_ONE  = UNIT_W'(1);
    localparam logic signed [UNIT_W-1:0] STEP_MONE = -STEP_ONE;
    localparam logic signed [UNIT_W-1:0] STEP_EDGE = UNIT_W'(EDGE_CELLS);
    localparam logic signed [UNIT_W-1:0] STEP_MEDG = -STEP_EDGE;
    localparam logic signed [1:0]        D_NONE    = 2'sb00;
    localparam logic signed [1:0]        D_INC     = 2'sb01;
    localparam logic signed [1:0]        D_DEC     = 2'sb11;

    localparam logic [2:0] SCAN_LAST  = 3'd7;
    localparam logic [2:0] SCAN_FACES = 3'(NUM_FACES);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IDX,
        ST_WRITE,
        ST_CENTRE,
        ST_WX,
        ST_WY,
        ST_WZ,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // ------------------------------------------------------------------------
    // Helper functions
    // ------------------------------------------------------------------------
    function automatic logic coord_ok(input logic signed [COORD_W-1:0] c);
        return (c[COORD_W-1] == 1'b0) && ($unsigned(c) < EDGE_U);
    endfunction

    function automatic logic signed [UNIT_W-1:0] ext_coord(
        input logic signed [COORD_W-1:0] c);
        return $signed({{(UNIT_W-COORD_W){c[COORD_W-1]}}, c});
    endfunction

    function automatic logic signed [UNIT_W-1:0] ext_origin(
        input logic [ORIGIN_W-1:0] o);
        return $signed({{(UNIT_W-ORIGIN_W){o[ORIGIN_W-1]}}, o});
    endfunction

    // Whether the neighbour across a face lies in the cube, for a cell inside.
    function automatic logic nb_inside(input logic [FACE_W-1:0] face,
                                       input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y,
                                       input logic [COORD_W-1:0] z);
        logic ok;
        case (face)
            FACE_TOP:    ok = (y != EDGE_MAX);
            FACE_BOTTOM: ok = (y != '0);
            FACE_LEFT:   ok = (x != '0);
            FACE_RIGHT:  ok = (x != EDGE_MAX);
            FACE_FRONT:  ok = (z != '0);
            FACE_BACK:   ok = (z != EDGE_MAX);
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;
    logic [ORIGIN_W-1:0] origin_z_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ORIGIN_X: origin_x_reg <= cfg.data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg.data;
                CFG_ORIGIN_Z: origin_z_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------------
    state_t                     state_reg,     state_next;
    logic                       kind_reg,      kind_next;
    logic signed [COORD_W-1:0]  x_reg,         x_next;
    logic signed [COORD_W-1:0]  y_reg,         y_next;
    logic signed [COORD_W-1:0]  z_reg,         z_next;
    logic [TYPE_W-1:0]          new_type_reg,  new_type_next;
    logic [TYPE_W-1:0]          ctype_reg,     ctype_next;
    logic [IDX_W-1:0]           idx_reg,       idx_next;
    logic [IDX_W-1:0]           clr_cnt_reg,   clr_cnt_next;
    logic [VERT_W-1:0]          wx_reg,        wx_next;
    logic [VERT_W-1:0]          wy_reg,        wy_next;
    logic [VERT_W-1:0]          wz_reg,        wz_next;
    logic [NUM_FACES-1:0]       mask_reg,      mask_next;
    logic [2:0]                 scan_cnt_reg,  scan_cnt_next;
    logic [FACE_W-1:0]          face_reg,      face_next;
    logic [VTX_W-1:0]           vtx_reg,       vtx_next;
    logic                       out_valid_reg, out_valid_next;
    logic [VERT_W-1:0]          out_x_reg,     out_x_next;
    logic [VERT_W-1:0]          out_y_reg,     out_y_next;
    logic [VERT_W-1:0]          out_z_reg,     out_z_next;
    logic [FACE_W-1:0]          out_face_reg,  out_face_next;
    logic [TYPE_W-1:0]          out_type_reg,  out_type_next;
    logic                       out_last_reg,  out_last_next;

    // Shared unit and store connections
    logic                       mac_en;
    logic signed [UNIT_W-1:0]   mac_a;
    logic signed [UNIT_W-1:0]   mac_c;
    logic signed [1:0]          mac_d;
    logic signed [UNIT_W-1:0]   mac_result;
    logic                       ram_wr_en;
    logic [IDX_W-1:0]           ram_wr_addr;
    logic [TYPE_W-1:0]          ram_wr_data;
    logic                       ram_rd_en;
    logic [TYPE_W-1:0]          ram_rd_data;

    // Emission helpers
    logic [2:0]                 corner;
    logic [NUM_FACES-1:0]       face_bit;
    logic                       slot_free;
    logic                       is_last;
    logic [FACE_W-1:0]          rd_face;
    logic [FACE_W-1:0]          chk_face;
    logic                       in_inside;

    vfc_mac #(
        .EDGE_CELLS (EDGE_CELLS),
        .UNIT_W     (UNIT_W)
    ) u_mac (
        .clk    (clk),
        .en     (mac_en),
        .a      (mac_a),
        .c      (mac_c),
        .d      (mac_d),
        .result (mac_result)
    );

    vfc_ram #(
        .WIDTH (TYPE_W),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (mac_result[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign item_in.ready = (state_reg == ST_IDLE);
    assign in_inside     = coord_ok(item_in.cell_x) && coord_ok(item_in.cell_y) &&
                           coord_ok(item_in.cell_z);

    assign corner    = face_corner(face_reg, vtx_reg);
    assign face_bit  = NUM_FACES'(1'b1) << face_reg;
    assign slot_free = !out_valid_reg || vertex_out.ready;
    assign is_last   = (vtx_reg == LAST_VTX) && ((mask_reg & ~face_bit) == '0);
    assign rd_face   = FACE_W'(scan_cnt_reg - 3'd1);
    assign chk_face  = FACE_W'(scan_cnt_reg - 3'd2);

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        new_type_next  = new_type_reg;
        ctype_next     = ctype_reg;
        idx_next       = idx_reg;
        clr_cnt_next   = clr_cnt_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        wz_next        = wz_reg;
        mask_next      = mask_reg;
        scan_cnt_next  = scan_cnt_reg;
        face_next      = face_reg;
        vtx_next       = vtx_reg;
        out_valid_next = out_valid_reg && !vertex_out.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_face_next  = out_face_reg;
        out_type_next  = out_type_reg;
        out_last_next  = out_last_reg;

        mac_en      = 1'b0;
        mac_a       = '0;
        mac_c       = '0;
        mac_d       = D_NONE;
        ram_wr_en   = 1'b0;
        ram_wr_addr = mac_result[IDX_W-1:0];
        ram_wr_data = new_type_reg;
        ram_rd_en   = 1'b0;

        case (state_reg)
            // Zero the store one cell per cycle after reset
            ST_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            // Take an item and start x * E + y for a cell in the cube
            ST_IDLE:
            begin
                if (item_in.valid)
                begin
                    kind_next     = item_in.kind;
                    x_next        = item_in.cell_x;
                    y_next        = item_in.cell_y;
                    z_next        = item_in.cell_z;
                    new_type_next = item_in.new_type;
                    mac_en        = 1'b1;
                    mac_a         = ext_coord(item_in.cell_x);
                    mac_c         = ext_coord(item_in.cell_y);
                    if (in_inside)
                    begin
                        state_next = ST_IDX;
                    end
                end
            end

            // Finish the cell index: (x * E + y) * E + z
            ST_IDX:
            begin
                mac_en = 1'b1;
                mac_a  = mac_result;
                mac_c  = ext_coord(z_reg);
                state_next = (kind_reg == KIND_WRITE) ? ST_WRITE : ST_CENTRE;
            end

            ST_WRITE:
            begin
                ram_wr_en  = 1'b1;
                state_next = ST_IDLE;
            end

            // Read the meshed cell and start the world base along x
            ST_CENTRE:
            begin
                ram_rd_en  = 1'b1;
                idx_next   = mac_result[IDX_W-1:0];
                mac_en     = 1'b1;
                mac_a      = ext_origin(origin_x_reg);
                mac_c      = ext_coord(x_reg);
                state_next = ST_WX;
            end

            ST_WX:
            begin
                ctype_next = ram_rd_data;
                wx_next    = mac_result[VERT_W-1:0];
                mac_en     = 1'b1;
                mac_a      = ext_origin(origin_y_reg);
                mac_c      = ext_coord(y_reg);
                state_next = (ram_rd_data == '0) ? ST_IDLE : ST_WY;
            end

            ST_WY:
            begin
                wy_next    = mac_result[VERT_W-1:0];
                mac_en     = 1'b1;
                mac_a      = ext_origin(origin_z_reg);
                mac_c      = ext_coord(z_reg);
                state_next = ST_WZ;
            end

            ST_WZ:
            begin
                wz_next       = mac_result[VERT_W-1:0];
                mask_next     = '0;
                scan_cnt_next = '0;
                state_next    = ST_SCAN;
            end

            // Neighbour scan: the address, read and check steps of successive faces overlap
            ST_SCAN:
            begin
                if (scan_cnt_reg < SCAN_FACES)
                begin
                    mac_en = 1'b1;
                    mac_c  = $signed({{(UNIT_W-IDX_W){1'b0}}, idx_reg});
                    case (FACE_W'(scan_cnt_reg))
                        FACE_TOP:    mac_a = STEP_ONE;
                        FACE_BOTTOM: mac_a = STEP_MONE;
                        FACE_LEFT:   mac_a = STEP_MEDG;
                        FACE_RIGHT:  mac_a = STEP_EDGE;
                        FACE_FRONT:  mac_d = D_DEC;
                        FACE_BACK:   mac_d = D_INC;
                        default:     mac_a = '0;
                    endcase
                end
                if ((scan_cnt_reg != '0) && (scan_cnt_reg <= SCAN_FACES))
                begin
                    ram_rd_en = nb_inside(rd_face, x_reg, y_reg, z_reg);
                end
                if (scan_cnt_reg >= 3'd2)
                begin
                    mask_next[chk_face] = !nb_inside(chk_face, x_reg, y_reg, z_reg) ||
                                          (ram_rd_data == '0);
                end
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCAN_LAST)
                begin
                    face_next  = '0;
                    vtx_next   = '0;
                    state_next = (mask_next == '0) ? ST_IDLE : ST_EMIT;
                end
            end

            // Emit six vertices for each exposed face
            ST_EMIT:
            begin
                if (!mask_reg[face_reg])
                begin
                    face_next = face_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = wx_reg + VERT_W'(corner[2]);
                    out_y_next     = wy_reg + VERT_W'(corner[1]);
                    out_z_next     = wz_reg + VERT_W'(corner[0]);
                    out_face_next  = face_reg;
                    out_type_next  = ctype_reg;
                    out_last_next  = is_last;
                    if (vtx_reg == LAST_VTX)
                    begin
                        vtx_next            = '0;
                        mask_next[face_reg] = 1'b0;
                        face_next           = face_reg + 1'b1;
                    end
                    else
                    begin
                        vtx_next = vtx_reg + 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            kind_reg      <= KIND_WRITE;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            new_type_reg  <= '0;
            ctype_reg     <= '0;
            idx_reg       <= '0;
            clr_cnt_reg   <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            wz_reg        <= '0;
            mask_reg      <= '0;
            scan_cnt_reg  <= '0;
            face_reg      <= '0;
            vtx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_face_reg  <= '0;
            out_type_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            new_type_reg  <= new_type_next;
            ctype_reg     <= ctype_next;
            idx_reg       <= idx_next;
            clr_cnt_reg   <= clr_cnt_next;
            wx_reg        <= wx_next;
            wy_reg        <= wy_next;
            wz_reg        <= wz_next;
            mask_reg      <= mask_next;
            scan_cnt_reg  <= scan_cnt_next;
            face_reg      <= face_next;
            vtx_reg       <= vtx_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_z_reg     <= out_z_next;
            out_face_reg  <= out_face_next;
            out_type_reg  <= out_type_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Output channel
    assign vertex_out.valid       = out_valid_reg;
    assign vertex_out.vertex_x    = $signed(out_x_reg);
    assign vertex_out.vertex_y    = $signed(out_y_reg);
    assign vertex_out.vertex_z    = $signed(out_z_reg);
    assign vertex_out.face_dir    = out_face_reg;
    assign vertex_out.cell_type   = out_type_reg;
    assign vertex_out.last_vertex = out_last_reg;

endmodule

@@ hdl/vfc_ram.sv @@
// ----------------------------------------------------------------------------
// vfc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vfc_ram
#(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/vfc_mac.sv @@
// ----------------------------------------------------------------------------
// vfc_mac
// Shared multiply-by-edge and add unit: result = a * EDGE_CELLS + c + d.
// It builds cell indexes, neighbour indexes and world base coordinates.
// ----------------------------------------------------------------------------
module vfc_mac
#(
    parameter int EDGE_CELLS = 16,
    parameter int UNIT_W     = 20
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [UNIT_W-1:0] a,
    input  logic signed [UNIT_W-1:0] c,
    input  logic signed [1:0]        d,
    output logic signed [UNIT_W-1:0] result
);

    localparam logic signed [UNIT_W-1:0] EDGE_S = UNIT_W'(EDGE_CELLS);

    logic signed [UNIT_W-1:0] d_ext;
    logic signed [UNIT_W-1:0] sum;

    // One constant multiply and a three-input add
    assign d_ext = $signed({{(UNIT_W-2){d[1]}}, d});
    assign sum   = a * EDGE_S + c + d_ext;

    // Result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result <= sum;
        end
    end

endmodule

@@ tb/voxel_face_cull_mesher_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher_unit_tb
// Self-checking bench for the voxel face-cull mesher. Write and mesh items are
// sent in random bursts while the vertex channel stalls on its own pattern. A
// scoreboard keeps its own copy of the cell cube and the chunk origin. It
// works out every vertex that a mesh item must produce and compares the
// vertices that come back, in order and field by field.
// ----------------------------------------------------------------------------
module voxel_face_cull_mesher_unit_tb;
    import vfc_pkg::*;

    localparam int CUBE_EDGE     = EDGE_CELLS_DEF;
    localparam int CUBE_CELLS    = CUBE_EDGE * CUBE_EDGE * CUBE_EDGE;
    localparam int PHASE_ITEMS   = 98;
    localparam int RANDOM_PHASES = 4;
    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PRINT_CAP     = 40;

    // Corner offsets of each face, six vertices of {x, y, z} from the left.
    localparam bit [0:17] OFS_TOP    = 18'b010_011_110_110_011_111;
    localparam bit [0:17] OFS_BOTTOM = 18'b000_100_001_100_101_001;
    localparam bit [0:17] OFS_LEFT   = 18'b011_001_010_010_001_000;
    localparam bit [0:17] OFS_RIGHT  = 18'b110_100_111_111_100_101;
    localparam bit [0:17] OFS_FRONT  = 18'b010_000_110_110_000_100;
    localparam bit [0:17] OFS_BACK   = 18'b111_101_011_011_101_001;

    typedef struct {
        logic                      kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [TYPE_W-1:0]         ntype;
    } cell_item_t;

    typedef struct {
        logic signed [VERT_W-1:0] vx;
        logic signed [VERT_W-1:0] vy;
        logic signed [VERT_W-1:0] vz;
        logic [FACE_W-1:0]        face;
        logic [TYPE_W-1:0]        ctype;
        logic                     last;
    } vertex_t;

    // ------------------------------------------------------------------------
    // Scoreboard: cube contents, chunk origin and the vertices still awaited.
    // ------------------------------------------------------------------------
    class mesh_scoreboard;
        logic [TYPE_W-1:0]          cube [CUBE_CELLS];
        logic signed [ORIGIN_W-1:0] org_x;
        logic signed [ORIGIN_W-1:0] org_y;
        logic signed [ORIGIN_W-1:0] org_z;
        vertex_t                    vertex_q [$];
        int errors;
        int writes;
        int meshes;
        int vertices;
        int culled;
        int settings;

        function new();
            foreach (cube[i])
                cube[i] = '0;
            org_x = '0;
            org_y = '0;
            org_z = '0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        function void set_origin(logic [CFG_IDX_W-1:0] idx, logic [ORIGIN_W-1:0] val);
            case (idx)
                CFG_ORIGIN_X: org_x = val;
                CFG_ORIGIN_Y: org_y = val;
                CFG_ORIGIN_Z: org_z = val;
                default: ;
            endcase
        endfunction

        function bit in_cube(int x, int y, int z);
            return x >= 0 && x < CUBE_EDGE && y >= 0 && y < CUBE_EDGE &&
                   z >= 0 && z < CUBE_EDGE;
        endfunction

        // Cells outside the cube read as empty.
        function logic [TYPE_W-1:0] cell_at(int x, int y, int z);
            if (!in_cube(x, y, z))
                return '0;
            return cube[(x * CUBE_EDGE + y) * CUBE_EDGE + z];
        endfunction

        function int corner(logic [FACE_W-1:0] fc, int k, int axis);
            bit [0:17] row;
            case (fc)
                FACE_TOP:    row = OFS_TOP;
                FACE_BOTTOM: row = OFS_BOTTOM;
                FACE_LEFT:   row = OFS_LEFT;
                FACE_RIGHT:  row = OFS_RIGHT;
                FACE_FRONT:  row = OFS_FRONT;
                default:     row = OFS_BACK;
            endcase
            return int'(row[k * 3 + axis]);
        endfunction

        // World coordinate, exact and then wrapped to the vertex width.
        function logic [VERT_W-1:0] world(logic signed [ORIGIN_W-1:0] org, int pos, int ofs);
            int w;
            w = int'(org) * CUBE_EDGE + pos + ofs;
            return w[VERT_W-1:0];
        endfunction

        // Applies a write, or queues the vertices that a mesh item produces.
        function void note_item(cell_item_t it);
            int x;
            int y;
            int z;
            int dx;
            int dy;
            int dz;
            int count;
            logic [TYPE_W-1:0] ctype;
            logic [FACE_W-1:0] fc;
            vertex_t vtx;
            x = it.x;
            y = it.y;
            z = it.z;
            if (it.kind == KIND_WRITE) begin
                writes++;
                if (in_cube(x, y, z))
                    cube[(x * CUBE_EDGE + y) * CUBE_EDGE + z] = it.ntype;
                return;
            end
            meshes++;
            ctype = cell_at(x, y, z);
            if (ctype == '0)
                return;
            count = 0;
            for (int f = 0; f < NUM_FACES; f++) begin
                fc = FACE_W'(f);
                dx = 0;
                dy = 0;
                dz = 0;
                case (fc)
                    FACE_TOP:    dy = 1;
                    FACE_BOTTOM: dy = -1;
                    FACE_LEFT:   dx = -1;
                    FACE_RIGHT:  dx = 1;
                    FACE_FRONT:  dz = -1;
                    default:     dz = 1;
                endcase
                if (cell_at(x + dx, y + dy, z + dz) != '0) begin
                    culled++;
                    continue;
                end
                for (int k = 0; k < VTX_PER_FACE; k++) begin
                    vtx.vx    = world(org_x, x, corner(fc, k, 0));
                    vtx.vy    = world(org_y, y, corner(fc, k, 1));
                    vtx.vz    = world(org_z, z, corner(fc, k, 2));
                    vtx.face  = fc;
                    vtx.ctype = ctype;
                    vtx.last  = 1'b0;
                    vertex_q.insert(vertex_q.size(), vtx);
                    count++;
                end
            end
            if (count > 0)
                vertex_q[vertex_q.size() - 1].last = 1'b1;
        endfunction

        task check_vertex(vertex_t got);
            vertex_t want;
            if (vertex_q.size() == 0) begin
                report($sformatf("vertex (%0d,%0d,%0d) face %0d with nothing expected",
                                 got.vx, got.vy, got.vz, got.face));
                return;
            end
            want = vertex_q.pop_front();
            vertices++;
            if (got.vx !== want.vx)
                report($sformatf("vertex_x %0d, expected %0d", got.vx, want.vx));
            if (got.vy !== want.vy)
                report($sformatf("vertex_y %0d, expected %0d", got.vy, want.vy));
            if (got.vz !== want.vz)
                report($sformatf("vertex_z %0d, expected %0d", got.vz, want.vz));
            if (got.face !== want.face)
                report($sformatf("face_dir %0d, expected %0d", got.face, want.face));
            if (got.ctype !== want.ctype)
                report($sformatf("cell_type %0d, expected %0d", got.ctype, want.ctype));
            if (got.last !== want.last)
                report($sformatf("last_vertex %0b, expected %0b", got.last, want.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   idle_cycles = 0;
    int   stall_count = 0;
    int   stall_mode  = 0;
    mesh_scoreboard sb;

    vfc_cfg_if    cfg_bus ();
    vfc_item_if   item_bus ();
    vfc_vertex_if vertex_bus ();

    voxel_face_cull_mesher_unit #(
        .EDGE_CELLS (CUBE_EDGE)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .item_in    (item_bus),
        .vertex_out (vertex_bus)
    );

    // Clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Vertex receiver: checks accepted vertices and stalls in changing modes.
    always @(posedge clk)
    begin : vertex_receiver
        vertex_t got;
        if (vertex_bus.valid === 1'b1 && vertex_bus.ready === 1'b1) begin
            got.vx    = vertex_bus.vertex_x;
            got.vy    = vertex_bus.vertex_y;
            got.vz    = vertex_bus.vertex_z;
            got.face  = vertex_bus.face_dir;
            got.ctype = vertex_bus.cell_type;
            got.last  = vertex_bus.last_vertex;
            sb.check_vertex(got);
        end
        if (stall_count % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        stall_count <= stall_count + 1;
        case (stall_mode)
            0:       vertex_bus.ready <= 1'b1;
            1:       vertex_bus.ready <= ($urandom_range(0, 3) != 0);
            2:       vertex_bus.ready <= ($urandom_range(0, 3) == 0);
            default: vertex_bus.ready <= (stall_count % 5 != 0);
        endcase
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
            (vertex_bus.valid === 1'b1 && vertex_bus.ready === 1'b1) ||
            (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without progress", idle_cycles);
            $display("voxel_face_cull_mesher_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic cell_item_t cell_op(logic kind, int x, int y, int z, int ntype);
        cell_item_t it;
        it.kind  = kind;
        it.x     = COORD_W'(x);
        it.y     = COORD_W'(y);
        it.z     = COORD_W'(z);
        it.ntype = TYPE_W'(ntype);
        return it;
    endfunction

    // Coordinate near a cluster base, now and then one step past its edges.
    function automatic int near_base(int base);
        if ($urandom_range(0, 9) == 0)
            return base + int'($urandom_range(0, 5)) - 1;
        return base + int'($urandom_range(0, 3));
    endfunction

    function automatic int pick_base();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return CUBE_EDGE - 4;
            default: return int'($urandom_range(0, CUBE_EDGE - 4));
        endcase
    endfunction

    // Mostly dense writes and meshes in a small cluster; the rest is noise.
    function automatic cell_item_t random_item(int bx, int by, int bz);
        cell_item_t it;
        if ($urandom_range(0, 99) < 8) begin
            it.kind  = 1'($urandom_range(0, 1));
            it.x     = COORD_W'($urandom);
            it.y     = COORD_W'($urandom);
            it.z     = COORD_W'($urandom);
            it.ntype = TYPE_W'($urandom);
        end else begin
            it.kind  = ($urandom_range(0, 99) < 45) ? KIND_WRITE : KIND_MESH;
            it.x     = COORD_W'(near_base(bx));
            it.y     = COORD_W'(near_base(by));
            it.z     = COORD_W'(near_base(bz));
            it.ntype = ($urandom_range(0, 3) == 0) ? '0 : TYPE_W'($urandom_range(1, 255));
        end
        return it;
    endfunction

    task automatic send_item(input cell_item_t it);
        item_bus.valid    <= 1'b1;
        item_bus.kind     <= it.kind;
        item_bus.cell_x   <= it.x;
        item_bus.cell_y   <= it.y;
        item_bus.cell_z   <= it.z;
        item_bus.new_type <= it.ntype;
        do @(posedge clk); while (item_bus.ready !== 1'b1);
        sb.note_item(it);
    endtask

    task automatic pause_items(input int cycles);
        if (cycles > 0) begin
            item_bus.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Holds the sender until every awaited vertex has come back.
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        while (sb.vertex_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ORIGIN_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        sb.set_origin(idx, val);
    endtask

    task automatic load_origins(input logic [ORIGIN_W-1:0] ox, input logic [ORIGIN_W-1:0] oy,
                                input logic [ORIGIN_W-1:0] oz);
        cfg_write(CFG_ORIGIN_X, ox);
        cfg_write(CFG_ORIGIN_Y, oy);
        cfg_write(CFG_ORIGIN_Z, oz);
        cfg_bus.valid <= 1'b0;
        sb.settings++;
    endtask

    // Directed items: cube corners, out-of-cube cells, enclosure and clearing.
    task automatic run_directed();
        send_item(cell_op(KIND_MESH, 0, 0, 0, 0));
        send_item(cell_op(KIND_WRITE, 0, 0, 0, 255));
        send_item(cell_op(KIND_MESH, 0, 0, 0, 0));
        send_item(cell_op(KIND_WRITE, 15, 15, 15, 1));
        send_item(cell_op(KIND_MESH, 15, 15, 15, 0));
        send_item(cell_op(KIND_MESH, -1, 0, 0, 0));
        send_item(cell_op(KIND_MESH, 16, 0, 0, 0));
        send_item(cell_op(KIND_WRITE, -128, 127, -1, 170));
        send_item(cell_op(KIND_MESH, -128, 127, 5, 0));
        send_item(cell_op(KIND_MESH, 0, 0, 0, 0));
        // A solid cell with all six neighbours filled shows no face.
        send_item(cell_op(KIND_WRITE, 5, 5, 5, 7));
        send_item(cell_op(KIND_WRITE, 5, 6, 5, 128));
        send_item(cell_op(KIND_WRITE, 5, 4, 5, 3));
        send_item(cell_op(KIND_WRITE, 4, 5, 5, 85));
        send_item(cell_op(KIND_WRITE, 6, 5, 5, 254));
        send_item(cell_op(KIND_WRITE, 5, 5, 4, 64));
        send_item(cell_op(KIND_WRITE, 5, 5, 6, 2));
        send_item(cell_op(KIND_MESH, 5, 5, 5, 0));
        send_item(cell_op(KIND_MESH, 5, 6, 5, 0));
        // Clearing the cell above uncovers the top face only.
        send_item(cell_op(KIND_WRITE, 5, 6, 5, 0));
        send_item(cell_op(KIND_MESH, 5, 5, 5, 0));
    endtask

    // Stimulus and end of run.
    initial
    begin
        int burst_left;
        int gap;
        int bx;
        int by;
        int bz;
        sb = new();
        rst_n               = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_ORIGIN_X;
        cfg_bus.data        = '0;
        item_bus.valid      = 1'b0;
        item_bus.kind       = KIND_WRITE;
        item_bus.cell_x     = '0;
        item_bus.cell_y     = '0;
        item_bus.cell_z     = '0;
        item_bus.new_type   = '0;
        vertex_bus.ready    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_origins('0, '0, '0);
        run_directed();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // Origin changes only once the block has gone quiet.
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (p)
                0:       load_origins(12'h7FF, 12'h800, 12'h7FF);
                1:       load_origins(12'h800, 12'h7FF, 12'h800);
                default: load_origins(ORIGIN_W'($urandom), ORIGIN_W'($urandom),
                                      ORIGIN_W'($urandom));
            endcase
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0) begin
                    bx = pick_base();
                    by = pick_base();
                    bz = pick_base();
                end
                if (n == PHASE_ITEMS / 2 || $urandom_range(0, 49) == 0)
                    wait_drained();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap = ($urandom_range(0, 3) == 0 || p == 2) ? 0 : $urandom_range(1, 10);
                    pause_items(gap);
                end
                burst_left--;
                send_item(random_item(bx, by, bz));
            end
        end

        // Let every vertex arrive, then watch for strays.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.vertex_q.size() != 0)
            sb.report($sformatf("%0d vertices never arrived", sb.vertex_q.size()));

        $display("Sent %0d writes and %0d mesh items over %0d origin settings.",
                 sb.writes, sb.meshes, sb.settings);
        $display("Checked %0d vertices; %0d faces hidden by solid neighbours; %0d errors.",
                 sb.vertices, sb.culled, sb.errors);
        if (sb.errors == 0)
            $display("voxel_face_cull_mesher_unit verification clean");
        else
            $display("voxel_face_cull_mesher_unit verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/vfc_pkg.sv
hdl/vfc_if.sv
hdl/vfc_ram.sv
hdl/vfc_mac.sv
hdl/voxel_face_cull_mesher_unit.sv
tb/voxel_face_cull_mesher_unit_tb.sv
